FILE: design/assert_macros.svh
// Assertion helper macros shared by the receiver RTL.
// No dependencies; include once per file that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/efrc_pkg.sv
// Types, codes and the CRC-8 step for the escaped frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package efrc_pkg;

  // Receiver mode
  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_FRAME,
    MODE_ESC
  } mode_t;

  // Control sequencer
  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_READ,
    ST_SEND
  } ctrl_t;

  // Error causes
  typedef enum logic [1:0] {
    CAUSE_UNEXPECTED,
    CAUSE_CRC,
    CAUSE_OVERFLOW
  } cause_t;

  localparam logic KIND_DATA  = 1'b0;
  localparam logic KIND_ERROR = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_START  = 2'd0;
  localparam logic [1:0] REG_STOP   = 2'd1;
  localparam logic [1:0] REG_ESCAPE = 2'd2;

  localparam logic [7:0] START_RESET  = 8'd126;
  localparam logic [7:0] STOP_RESET   = 8'd127;
  localparam logic [7:0] ESCAPE_RESET = 8'd125;

  // Reflected CRC-8 (poly 0x31): contribution of each bit of crc^data
  localparam logic [7:0] CRC_BIT_TABLE [8] = '{
    8'h5e, 8'hbc, 8'h61, 8'hc2, 8'h9d, 8'h23, 8'h46, 8'h8c
  };

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] x;
    logic [7:0] r;
    x = crc ^ b;
    r = '0;
    for (int k = 0; k < 8; k++) begin
      if (x[k]) r = r ^ CRC_BIT_TABLE[k];
    end
    return r;
  endfunction

endpackage

FILE: design/escaped_frame_receiver_crc8.sv
// Escaped frame receiver with CRC-8 check.
// Uses efrc_pkg, efrc_store and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_ready, byte_in): one link byte per beat.
//   Start, stop and escape values come from three config registers written
//   through cfg_write/cfg_index/cfg_data (index 3 is ignored); write them
//   only while the block is idle.
//   Output channel (out_valid/out_ready): one result per beat. A good
//   frame comes out as a run of data beats (kind 0), the CRC byte last,
//   with is_last on the final beat and frame_length on every beat. Any
//   framing error, CRC mismatch or overflow gives one error beat (kind 1,
//   is_last 1, error_cause set) and drops the frame.
// Timing: a byte that only moves the mode or stores does not hold up the
//   next one. Error beats are registered and appear in the cycle after the
//   offending byte. Delivering a frame takes a store read (registered read
//   data, ST_READ) and then a load of the output register (ST_SEND) for
//   each beat. No input is taken while a frame is being played out.
// Stalls: the output register holds one beat; while it is full and
//   out_ready is low, in_ready stays low and delivery pauses.
// Reset (rst, synchronous): idle mode, empty store, output empty, config
//   registers back to 126/127/125. The store itself needs no clearing.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module escaped_frame_receiver_crc8 #(
  parameter int FRAME_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  // config
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  // link bytes
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] byte_in,
  // results
  output logic       out_valid,
  input  logic       out_ready,
  output logic       kind,
  output logic [7:0] byte_value,
  output logic       is_last,
  output logic [1:0] error_cause,
  output logic [5:0] frame_length
);

  localparam int AW = $clog2(FRAME_DEPTH);
  localparam int XW = (AW > 6) ? AW : 6;
  // storing at this fill count fills the store
  localparam logic [AW-1:0] FULL_AT = AW'(FRAME_DEPTH - 1);

  // config registers
  logic [7:0] start_value;
  logic [7:0] stop_value;
  logic [7:0] escape_value;

  // receiver state
  efrc_pkg::ctrl_t state, state_next;
  efrc_pkg::mode_t mode, mode_next;
  logic [AW-1:0]   fill_count, fill_next;
  logic [7:0]      crc_except_last, crc_next;
  logic [7:0]      newest_byte, newest_next;
  logic [AW-1:0]   rd_addr;

  // per-beat decisions
  logic             in_fire;
  logic             is_start, is_stop, is_esc;
  logic             do_store;
  logic             err;
  efrc_pkg::cause_t err_cause;
  logic             deliver;
  logic             rd_en;
  logic             send_load;
  logic             send_last;
  logic [7:0]       rd_data;
  logic [XW-1:0]    len_ext;

  assign in_fire  = in_valid && in_ready;
  // priority: start over stop over escape
  assign is_start = (byte_in == start_value);
  assign is_stop  = !is_start && (byte_in == stop_value);
  assign is_esc   = !is_start && !is_stop && (byte_in == escape_value);

  assign send_last = (rd_addr == AW'(fill_count - 1'b1));
  assign len_ext   = XW'(fill_count);

  //--------------------------------------------------------------------
  // Config writes
  //--------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      start_value  <= efrc_pkg::START_RESET;
      stop_value   <= efrc_pkg::STOP_RESET;
      escape_value <= efrc_pkg::ESCAPE_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        efrc_pkg::REG_START:  start_value  <= cfg_data;
        efrc_pkg::REG_STOP:   stop_value   <= cfg_data;
        efrc_pkg::REG_ESCAPE: escape_value <= cfg_data;
        default: ;
      endcase
    end
  end

  //--------------------------------------------------------------------
  // Byte decode and receiver state update
  //--------------------------------------------------------------------
  always_comb begin
    mode_next   = mode;
    fill_next   = fill_count;
    crc_next    = crc_except_last;
    newest_next = newest_byte;
    do_store    = 1'b0;
    err         = 1'b0;
    err_cause   = efrc_pkg::CAUSE_UNEXPECTED;
    deliver     = 1'b0;

    if (in_fire) begin
      if (is_start) begin
        unique case (mode)
          efrc_pkg::MODE_IDLE: mode_next = efrc_pkg::MODE_FRAME;
          efrc_pkg::MODE_ESC:  do_store  = 1'b1;
          default:             err       = 1'b1;
        endcase
      end else if (is_stop) begin
        if (mode == efrc_pkg::MODE_FRAME && fill_count > AW'(1)) begin
          if (newest_byte != crc_except_last) begin
            err       = 1'b1;
            err_cause = efrc_pkg::CAUSE_CRC;
          end else begin
            deliver = 1'b1;
          end
        end else if (mode == efrc_pkg::MODE_ESC) begin
          do_store = 1'b1;
        end else begin
          err = 1'b1;
        end
      end else if (is_esc) begin
        unique case (mode)
          efrc_pkg::MODE_FRAME: mode_next = efrc_pkg::MODE_ESC;
          efrc_pkg::MODE_ESC:   do_store  = 1'b1;
          default:              err       = 1'b1;
        endcase
      end else if (mode == efrc_pkg::MODE_FRAME) begin
        do_store = 1'b1;
      end else begin
        err = 1'b1;
      end

      if (do_store) begin
        // CRC trails by one byte so the newest byte can be checked as the CRC
        if (fill_count != '0) crc_next = efrc_pkg::crc8_update(crc_except_last, newest_byte);
        newest_next = byte_in;
        fill_next   = fill_count + 1'b1;
        mode_next   = efrc_pkg::MODE_FRAME;
        if (fill_count == FULL_AT) begin
          err       = 1'b1;
          err_cause = efrc_pkg::CAUSE_OVERFLOW;
        end
      end

      if (err || deliver) begin
        mode_next   = efrc_pkg::MODE_IDLE;
        crc_next    = '0;
        newest_next = '0;
        // count survives delivery: it sets the run length
        if (err) fill_next = '0;
      end
    end

    if (send_load && send_last) fill_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode            <= efrc_pkg::MODE_IDLE;
      fill_count      <= '0;
      crc_except_last <= '0;
      newest_byte     <= '0;
      rd_addr         <= '0;
    end else begin
      mode            <= mode_next;
      fill_count      <= fill_next;
      crc_except_last <= crc_next;
      newest_byte     <= newest_next;
      if (deliver) begin
        rd_addr <= '0;
      end else if (send_load) begin
        rd_addr <= rd_addr + 1'b1;
      end
    end
  end

  //--------------------------------------------------------------------
  // Sequencer: accept bytes, or play a frame out of the store
  //--------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      efrc_pkg::ST_ACCEPT: if (deliver) state_next = efrc_pkg::ST_READ;
      efrc_pkg::ST_READ:   state_next = efrc_pkg::ST_SEND;
      efrc_pkg::ST_SEND: begin
        if (send_load) state_next = send_last ? efrc_pkg::ST_ACCEPT : efrc_pkg::ST_READ;
      end
      default: state_next = efrc_pkg::ST_ACCEPT;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    rd_en     = 1'b0;
    send_load = 1'b0;
    unique case (state)
      efrc_pkg::ST_ACCEPT: in_ready  = !out_valid || out_ready;
      efrc_pkg::ST_READ:   rd_en     = 1'b1;
      efrc_pkg::ST_SEND:   send_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efrc_pkg::ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  //--------------------------------------------------------------------
  // Frame store. Writes happen only in ST_ACCEPT and reads only in
  // ST_READ, so the same entry is never read and written together.
  //--------------------------------------------------------------------
  efrc_store #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (do_store),
    .wr_addr (fill_count),
    .wr_data (byte_in),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  //--------------------------------------------------------------------
  // Output register
  //--------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (err || send_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (err) begin
      kind         <= efrc_pkg::KIND_ERROR;
      byte_value   <= '0;
      is_last      <= 1'b1;
      error_cause  <= err_cause;
      frame_length <= '0;
    end else if (send_load) begin
      kind         <= efrc_pkg::KIND_DATA;
      byte_value   <= rd_data;
      is_last      <= send_last;
      error_cause  <= efrc_pkg::CAUSE_UNEXPECTED;
      frame_length <= len_ext[5:0];
    end
  end

  //--------------------------------------------------------------------
  // Assertions
  //--------------------------------------------------------------------
  `ASSERT_IMPLIES(a_no_rw_overlap, clk, rst, do_store, !rd_en,
                  "store written and read in the same cycle")
  `ASSERT_NEXT(a_addr_steps, clk, rst,
               (state == efrc_pkg::ST_SEND) && send_load && !send_last,
               (state == efrc_pkg::ST_READ) && (rd_addr == $past(rd_addr) + 1'b1),
               "delivery read address did not advance")
  `ASSERT_IMPLIES(a_last_clears, clk, rst,
                  out_valid && (kind == efrc_pkg::KIND_DATA) && is_last,
                  (fill_count == '0) && (mode == efrc_pkg::MODE_IDLE),
                  "receiver not cleared after frame delivery")

endmodule

FILE: design/efrc_store.sv
// Frame byte store: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps

module efrc_store #(
  parameter int FRAME_DEPTH = 64,
  localparam int AW = $clog2(FRAME_DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [FRAME_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: bench/efrc_result_checker.sv
// Result checker for the escaped frame receiver: tracks config writes and link beats,
// predicts the result beats and compares each accepted one in order.
// Depends on efrc_pkg (mode, cause, kind and register codes).
`timescale 1ns / 1ps

module efrc_result_checker
  import efrc_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] byte_in,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic       kind,
  input  logic [7:0] byte_value,
  input  logic       is_last,
  input  logic [1:0] error_cause,
  input  logic [5:0] frame_length,
  output int         mismatches,
  output int         outstanding
);

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
    logic       is_last;
    logic [1:0] cause;
    logic [5:0] frame_length;
  } link_result_t;

  link_result_t results_due[$];

  // framing codes as last written
  logic [7:0] start_code;
  logic [7:0] stop_code;
  logic [7:0] escape_code;

  // receiver shadow
  mode_t      rx_mode;
  logic [6:0] stored_count;
  logic [7:0] stored_bytes[DEPTH];
  logic [7:0] crc_prior;
  logic [7:0] newest;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // reflected CRC-8, poly 0x31, one byte shifted through bit by bit
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 8'h8c) : (c >> 1);
    return c;
  endfunction

  task automatic clear_rx();
    rx_mode      = MODE_IDLE;
    stored_count = '0;
    crc_prior    = '0;
    newest       = '0;
  endtask

  task automatic push_error(input cause_t cause);
    link_result_t r;
    r.kind         = KIND_ERROR;
    r.byte_value   = '0;
    r.is_last      = 1'b1;
    r.cause        = cause;
    r.frame_length = '0;
    results_due.push_back(r);
    clear_rx();
  endtask

  // good frame: every stored byte, crc included, one beat each
  task automatic push_frame();
    link_result_t r;
    for (int k = 0; k < stored_count; k++) begin
      r.kind         = KIND_DATA;
      r.byte_value   = stored_bytes[k];
      r.is_last      = (k == stored_count - 1);
      r.cause        = '0;
      r.frame_length = stored_count[5:0];
      results_due.push_back(r);
    end
    clear_rx();
  endtask

  // Classification order is start, stop, escape: first match wins.
  task automatic absorb_link_byte(input logic [7:0] b);
    if (b == start_code) begin
      if (rx_mode == MODE_IDLE) begin
        rx_mode = MODE_FRAME;
        return;
      end
      if (rx_mode != MODE_ESC) begin
        push_error(CAUSE_UNEXPECTED);
        return;
      end
    end else if (b == stop_code) begin
      if (rx_mode == MODE_FRAME && stored_count > 1) begin
        if (newest != crc_prior) push_error(CAUSE_CRC);
        else push_frame();
        return;
      end
      if (rx_mode != MODE_ESC) begin
        push_error(CAUSE_UNEXPECTED);
        return;
      end
    end else if (b == escape_code) begin
      if (rx_mode == MODE_FRAME) begin
        rx_mode = MODE_ESC;
        return;
      end
      if (rx_mode != MODE_ESC) begin
        push_error(CAUSE_UNEXPECTED);
        return;
      end
    end else if (rx_mode != MODE_FRAME) begin
      push_error(CAUSE_UNEXPECTED);
      return;
    end
    // literal byte goes into the store
    if (stored_count > 0) crc_prior = crc_step(crc_prior, newest);
    stored_bytes[stored_count] = b;
    newest       = b;
    stored_count = stored_count + 7'd1;
    rx_mode      = MODE_FRAME;
    if (stored_count >= DEPTH) push_error(CAUSE_OVERFLOW);
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_beat();
    link_result_t want;
    if (results_due.size() == 0) begin
      $error("result beat with nothing expected: kind %0d byte_value %0d", kind, byte_value);
      mismatches++;
      return;
    end
    want = results_due.pop_front();
    check_field("kind", want.kind, kind);
    check_field("byte_value", want.byte_value, byte_value);
    check_field("is_last", want.is_last, is_last);
    check_field("error_cause", want.cause, error_cause);
    check_field("frame_length", want.frame_length, frame_length);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      start_code  = START_RESET;
      stop_code   = STOP_RESET;
      escape_code = ESCAPE_RESET;
      clear_rx();
      results_due.delete();
    end else begin
      if (out_valid && out_ready) compare_beat();
      if (in_valid && in_ready) absorb_link_byte(byte_in);
      if (cfg_write) begin
        case (cfg_index)
          REG_START:  start_code  = cfg_data;
          REG_STOP:   stop_code   = cfg_data;
          REG_ESCAPE: escape_code = cfg_data;
          default: ;
        endcase
      end
    end
    outstanding = results_due.size();
  end

endmodule

FILE: bench/escaped_frame_receiver_crc8_test.sv
// Top of the escaped frame receiver bench: clock, reset, link stimulus, result
// back-pressure and the verdict. Depends on efrc_pkg, the receiver RTL and efrc_result_checker.
`timescale 1ns / 1ps

module escaped_frame_receiver_crc8_test;
  import efrc_pkg::*;

  localparam int FRAME_DEPTH  = 64;
  localparam int SETTLE       = 8;        // settling wait so a mode-only byte can retire
  localparam int LONG_HOLD    = 300;      // receiver hold-off, long enough to back up input
  localparam int LIMIT_CYCLES = 1000000;
  // index 3 maps to no register; writes there must change nothing
  localparam logic [1:0] REG_SPARE = 2'd3;

  logic       clk = 1'b0;
  logic       rst;
  logic       cfg_write;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] byte_in;
  logic       out_valid;
  logic       out_ready;
  logic       kind;
  logic [7:0] byte_value;
  logic       is_last;
  logic [1:0] error_cause;
  logic [5:0] frame_length;

  int mismatches;
  int outstanding;

  // shared stimulus knobs
  bit no_idle;        // both sides run without gaps while set
  bit hold_off_req;   // receiver takes one beat, then holds off with ready low
  int bytes_sent;
  int cycles;

  // framing codes currently in the block, mirrored for frame building
  logic [7:0] start_v;
  logic [7:0] stop_v;
  logic [7:0] esc_v;
  logic [7:0] frame_body[$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  escaped_frame_receiver_crc8 #(
    .FRAME_DEPTH(FRAME_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .byte_value  (byte_value),
    .is_last     (is_last),
    .error_cause (error_cause),
    .frame_length(frame_length)
  );

  efrc_result_checker #(
    .DEPTH(FRAME_DEPTH)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .byte_in     (byte_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .kind        (kind),
    .byte_value  (byte_value),
    .is_last     (is_last),
    .error_cause (error_cause),
    .frame_length(frame_length),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // --------------------------------------------------------------------------
  // Link side. Each beat may first wait idle for a random gap (none while no_idle).
  // valid is only dropped when a gap follows, so a back-to-back beat never
  // sees valid lowered and raised in the same step.
  // --------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    byte_in  <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  // byte that collides with a framing code gets an escape in front
  task automatic send_stuffed(input logic [7:0] b);
    if (b == start_v || b == stop_v || b == esc_v) send_byte(esc_v);
    send_byte(b);
  endtask

  // Sends frame_body wrapped in start/stop with its CRC-8 appended.
  // A bad frame has one CRC bit flipped so the check must fail.
  task automatic send_frame(input bit bad_crc);
    logic [7:0] crc;
    int k;
    crc = '0;
    send_byte(start_v);
    foreach (frame_body[i]) begin
      crc = crc ^ frame_body[i];
      for (k = 0; k < 8; k++) crc = crc[0] ? ((crc >> 1) ^ 8'h8c) : (crc >> 1);
      send_stuffed(frame_body[i]);
    end
    if (bad_crc) crc = crc ^ (8'd1 << $urandom_range(0, 7));
    send_stuffed(crc);
    send_byte(stop_v);
  endtask

  // framing codes show up often so escapes and priorities get hit
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 11))
      0: b = start_v;
      1: b = stop_v;
      2: b = esc_v;
      default: ;
    endcase
    return b;
  endfunction

  task automatic fill_body(input int n);
    frame_body.delete();
    repeat (n) frame_body.push_back(pick_byte());
  endtask

  // Drop valid, wait for every predicted beat, then let any mode-only byte
  // finish so the block is idle before a register write.
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_START:  start_v = value;
      REG_STOP:   stop_v  = value;
      REG_ESCAPE: esc_v   = value;
      default: ;
    endcase
  endtask

  task automatic set_framing(input logic [7:0] s, input logic [7:0] p, input logic [7:0] e);
    drain_and_settle();
    write_reg(REG_START, s);
    write_reg(REG_STOP, p);
    write_reg(REG_ESCAPE, e);
  endtask

  // Mostly well-formed frames with random content; the rest is noise,
  // bad CRCs, truncated frames, short frames and the odd overflow.
  task automatic run_random(input int count);
    int target;
    int pick;
    int n;
    target = bytes_sent + count;
    while (bytes_sent < target) begin
      pick    = $urandom_range(0, 99);
      no_idle = ($urandom_range(0, 7) == 0);
      if (pick < 65) begin
        if ($urandom_range(0, 24) == 0) n = FRAME_DEPTH - 2;
        else if ($urandom_range(0, 9) == 0) n = $urandom_range(9, 40);
        else n = $urandom_range(1, 8);
        fill_body(n);
        send_frame(1'b0);
      end else if (pick < 75) begin
        fill_body($urandom_range(1, 8));
        send_frame(1'b1);
      end else if (pick < 83) begin
        repeat ($urandom_range(1, 4)) send_byte(pick_byte());
      end else if (pick < 90) begin
        // frame cut short by a second start
        send_byte(start_v);
        repeat ($urandom_range(1, 5)) send_stuffed(pick_byte());
        send_byte(start_v);
      end else if (pick < 97) begin
        // stop after a single stored byte
        send_byte(start_v);
        send_stuffed(pick_byte());
        send_byte(stop_v);
      end else begin
        send_byte(start_v);
        repeat (FRAME_DEPTH) send_stuffed(pick_byte());
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result side: per beat, a random stretch with ready low (none while no_idle), then
  // ready high until a beat goes through. A hold-off request stalls it with ready held low.
  // --------------------------------------------------------------------------
  initial begin
    int w;
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        w = no_idle ? 0 : $urandom_range(0, 3);
        if (w > 0) begin
          out_ready <= 1'b0;
          repeat (w) @(negedge clk);
        end
        out_ready <= 1'b1;
        do @(posedge clk); while (!out_valid);
        @(negedge clk);
      end
    end
  end

  // Watchdog: covers a hang and expectations that never drain.
  initial begin
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("escaped_frame_receiver_crc8_test: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_START;
    cfg_data     = '0;
    in_valid     = 1'b0;
    byte_in      = '0;
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    bytes_sent   = 0;
    start_v      = START_RESET;
    stop_v       = STOP_RESET;
    esc_v        = ESCAPE_RESET;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset framing codes.
    // Stray stop, escape and plain bytes while idle, field extremes among them.
    send_byte(stop_v);
    send_byte(esc_v);
    send_byte(8'h00);
    send_byte(8'hff);
    // start inside a frame
    send_byte(start_v);
    send_byte(start_v);
    // escape followed by a plain byte
    send_byte(start_v);
    send_byte(esc_v);
    send_byte(8'h41);
    // stop with nothing stored, then with a single stored byte
    send_byte(start_v);
    send_byte(stop_v);
    send_byte(start_v);
    send_byte(8'h12);
    send_byte(stop_v);
    // smallest frame: one zero byte, CRC zero
    frame_body = '{8'h00};
    send_frame(1'b0);
    // every framing code carried literally
    frame_body = '{start_v, stop_v, esc_v, 8'hff, 8'h00};
    send_frame(1'b0);
    // CRC mismatch
    frame_body = '{8'ha5, 8'h5a};
    send_frame(1'b1);
    // store fills up: overflow
    send_byte(start_v);
    repeat (FRAME_DEPTH) send_stuffed(pick_byte());
    // largest frame that still delivers
    fill_body(FRAME_DEPTH - 2);
    send_frame(1'b0);

    // Long receiver hold-off while the sender keeps offering beats.
    drain_and_settle();
    hold_off_req = 1'b1;
    fill_body(12);
    send_frame(1'b0);
    repeat (6) send_byte(pick_byte());

    // Random phases over several framing code settings, extremes included.
    run_random(10);
    set_framing(8'h00, 8'hff, 8'h01);
    run_random(10);
    set_framing(8'hff, 8'h00, 8'h80);
    run_random(10);
    // start equal to stop: start wins
    set_framing(8'h7e, 8'h7e, 8'h7d);
    run_random(10);
    // start equal to escape: start wins
    set_framing(8'h33, 8'h44, 8'h33);
    run_random(10);
    // back to the reset codes, plus a write to the unused index
    set_framing(START_RESET, STOP_RESET, ESCAPE_RESET);
    write_reg(REG_SPARE, 8'h55);
    run_random(15);

    drain_and_settle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("escaped_frame_receiver_crc8_test: PASS");
    end else begin
      $display("escaped_frame_receiver_crc8_test: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+design
design/efrc_pkg.sv
design/efrc_store.sv
design/escaped_frame_receiver_crc8.sv
bench/efrc_result_checker.sv
bench/escaped_frame_receiver_crc8_test.sv
